### rtl/xxtea_pkg.sv
package xxtea_pkg;

  localparam logic [31:0] DELTA = 32'h9e37_79b9;
  localparam int unsigned RND_W = 6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INIT,
    S_LOAD,
    S_ROUND,
    S_READ,
    S_MIX,
    S_WRITE,
    S_EMIT_RD,
    S_EMIT_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CHECK,
    OP_INIT,
    OP_LOAD,
    OP_ROUND,
    OP_READ,
    OP_MIX,
    OP_WRITE,
    OP_EMIT_RD,
    OP_EMIT_OUT
  } dp_op_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] data_word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        out_last;
    status_e     status;
  } out_item_t;

  typedef struct packed {
    logic status_ok;
    logic step_last;
    logic rounds_done;
    logic emit_last;
  } dp_stat_t;

  function automatic logic [RND_W-1:0] rounds_for(input logic [6:0] n);
    logic [RND_W-1:0] r;
    if (n <= 7'd2)       r = 6'd32;
    else if (n == 7'd3)  r = 6'd23;
    else if (n == 7'd4)  r = 6'd19;
    else if (n == 7'd5)  r = 6'd16;
    else if (n == 7'd6)  r = 6'd14;
    else if (n == 7'd7)  r = 6'd13;
    else if (n == 7'd8)  r = 6'd12;
    else if (n <= 7'd10) r = 6'd11;
    else if (n <= 7'd13) r = 6'd10;
    else if (n <= 7'd17) r = 6'd9;
    else if (n <= 7'd26) r = 6'd8;
    else if (n <= 7'd52) r = 6'd7;
    else                 r = 6'd6;
    return r;
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] sum, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] key);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = (z >> 5) ^ (y << 2);
    b = (y >> 3) ^ (z << 4);
    c = sum ^ y;
    d = key ^ z;
    return (a + b) ^ (c + d);
  endfunction

endpackage

### rtl/xxtea_ctrl.sv
module xxtea_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_i,
  input  xxtea_pkg::dp_stat_t  stat_i,
  output xxtea_pkg::dp_op_e    op_o,
  output logic                 busy_o,
  output logic                 out_valid_o
);
  import xxtea_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && last_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.status_ok ? S_INIT : S_EMIT_RD;
      end
      S_INIT:  state_d = S_LOAD;
      S_LOAD:  state_d = S_ROUND;
      S_ROUND: state_d = S_READ;
      S_READ:  state_d = S_MIX;
      S_MIX:   state_d = S_WRITE;
      S_WRITE: begin
        if (!stat_i.step_last)       state_d = S_READ;
        else if (stat_i.rounds_done) state_d = S_EMIT_RD;
        else                         state_d = S_ROUND;
      end
      S_EMIT_RD:  state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        state_d = stat_i.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o        = OP_NONE;
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) op_o = OP_ACCEPT;
      end
      S_CHECK:   op_o = OP_CHECK;
      S_INIT:    op_o = OP_INIT;
      S_LOAD:    op_o = OP_LOAD;
      S_ROUND:   op_o = OP_ROUND;
      S_READ:    op_o = OP_READ;
      S_MIX:     op_o = OP_MIX;
      S_WRITE:   op_o = OP_WRITE;
      S_EMIT_RD: op_o = OP_EMIT_RD;
      S_EMIT_OUT: begin
        op_o        = OP_EMIT_OUT;
        out_valid_o = 1'b1;
      end
      default: op_o = OP_NONE;
    endcase
  end

endmodule

### rtl/xxtea_dp.sv
module xxtea_dp #(
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  xxtea_pkg::dp_op_e    op_i,
  input  xxtea_pkg::in_item_t  in_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output xxtea_pkg::dp_stat_t  stat_o,
  output xxtea_pkg::out_item_t out_o
);
  import xxtea_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WORDS);
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  logic [31:0]      mem [MAX_WORDS];
  logic [31:0]      key_q [4];
  logic [CW-1:0]    count_q;
  logic             mode_q;
  logic             ovf_q;
  status_e          status_q;
  logic [RND_W-1:0] rounds_q;
  logic [AW-1:0]    p_q;
  logic [31:0]      sum_q;
  logic [31:0]      chain_q;
  logic [31:0]      mx_q;
  logic [31:0]      rd_a_q;
  logic [31:0]      rd_b_q;

  logic          full;
  logic [AW-1:0] idx_last;
  logic [AW-1:0] nbr;
  logic [AW-1:0] rd_a_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          rd_en;
  logic [31:0]   new_word;
  logic [31:0]   sum_init;
  logic [1:0]    key_sel;
  logic [31:0]   mix_y;
  logic [31:0]   mix_z;
  logic          step_last;

  assign full      = (count_q == CW'(MAX_WORDS));
  assign idx_last  = AW'(count_q - 1'b1);
  assign step_last = mode_q ? (p_q == '0) : (p_q == idx_last);

  always_comb begin
    if (mode_q) nbr = (p_q == '0) ? idx_last : p_q - 1'b1;
    else        nbr = (p_q == idx_last) ? '0 : p_q + 1'b1;
  end

  assign rd_a_addr = (op_i == OP_INIT) ? (mode_q ? '0 : idx_last) : p_q;
  assign rd_en     = (op_i == OP_INIT) || (op_i == OP_READ) || (op_i == OP_EMIT_RD);
  assign new_word  = mode_q ? rd_a_q - mx_q : rd_a_q + mx_q;
  assign mem_we    = ((op_i == OP_ACCEPT) && !full) || (op_i == OP_WRITE);
  assign mem_waddr = (op_i == OP_WRITE) ? p_q : count_q[AW-1:0];
  assign mem_wdata = (op_i == OP_WRITE) ? new_word : in_i.data_word;
  assign sum_init  = (32'(rounds_q) + 32'd1) * DELTA;
  assign key_sel   = 2'(p_q) ^ sum_q[3:2];
  assign mix_y     = mode_q ? chain_q : rd_b_q;
  assign mix_z     = mode_q ? rd_b_q : chain_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      rd_a_q <= mem[rd_a_addr];
      rd_b_q <= mem[nbr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      mode_q   <= 1'b0;
      ovf_q    <= 1'b0;
      status_q <= ST_OK;
      rounds_q <= '0;
      p_q      <= '0;
    end else begin
      case (op_i)
        OP_ACCEPT: begin
          if (count_q == '0) mode_q <= in_i.mode;
          if (full) ovf_q   <= 1'b1;
          else      count_q <= count_q + 1'b1;
          if (in_i.last_word) begin
            if (ovf_q || full)        status_q <= ST_LONG;
            else if (count_q == '0)   status_q <= ST_SHORT;
            else                      status_q <= ST_OK;
          end
        end
        OP_CHECK: p_q <= '0;
        OP_INIT:  rounds_q <= rounds_for(7'(count_q));
        OP_ROUND: begin
          rounds_q <= rounds_q - 1'b1;
          p_q      <= mode_q ? idx_last : '0;
        end
        OP_WRITE: begin
          if (step_last)   p_q <= '0;
          else if (mode_q) p_q <= p_q - 1'b1;
          else             p_q <= p_q + 1'b1;
        end
        OP_EMIT_OUT: begin
          if (p_q == idx_last) begin
            count_q <= '0;
            mode_q  <= 1'b0;
            ovf_q   <= 1'b0;
          end else begin
            p_q <= p_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        chain_q <= rd_a_q;
        sum_q   <= mode_q ? sum_init : '0;
      end
      OP_ROUND: sum_q   <= mode_q ? sum_q - DELTA : sum_q + DELTA;
      OP_MIX:   mx_q    <= mix(sum_q, mix_y, mix_z, key_q[key_sel]);
      OP_WRITE: chain_q <= new_word;
      default: ;
    endcase
  end

  assign stat_o.status_ok   = (status_q == ST_OK);
  assign stat_o.step_last   = step_last;
  assign stat_o.rounds_done = (rounds_q == '0);
  assign stat_o.emit_last   = (p_q == idx_last);

  assign out_o.out_word = rd_a_q;
  assign out_o.out_last = (p_q == idx_last);
  assign out_o.status   = status_q;

endmodule

### rtl/xxtea_block_cipher_core.sv
// XXTEA block cipher core.
// Load the key through cfg_we_i / cfg_idx_i / cfg_data_i (index 0..3 = key words 0..3)
// while the core is idle. Feed one word per transfer: a transfer happens on a clock
// edge with start_i high and busy_o low. The mode bit of the first word selects
// encrypt (0) or decrypt (1); last_word closes the block. Words past MAX_WORDS are
// dropped and the block comes back unchanged with status 2; a one-word block comes
// back unchanged with status 1.
// After the last word busy_o rises and the core runs 6+52/n rounds on one shared
// mixer: each round opens with a round step, then each word step passes through a
// memory read, the mix, and an add and write back. Afterwards each word is emitted
// through a memory read and an output step.
// Results appear on out_o for one cycle each, marked by out_valid_o, with out_last on
// the final word; the receiver cannot stall, so results are never held.
// Reset clears the key to zero and drops any partly loaded block; the word store
// needs no clearing since only words of the current block are read.
module xxtea_block_cipher_core #(
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  xxtea_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  output xxtea_pkg::out_item_t out_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import xxtea_pkg::*;

  dp_op_e   op;
  dp_stat_t stat;

  xxtea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_i      (in_i.last_word),
    .stat_i      (stat),
    .op_o        (op),
    .busy_o      (busy_o),
    .out_valid_o (out_valid_o)
  );

  xxtea_dp #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_o     (stat),
    .out_o      (out_o)
  );

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result strobe outside a busy run");

  a_valid_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobes back to back");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && in_i.last_word))
    else $error("run started without a closing word");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(out_valid_o && out_o.out_last))
    else $error("run ended before the last result");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import xxtea_pkg::*;

  localparam int unsigned STORE_DEPTH   = 64;
  localparam logic [31:0] TEA_DELTA     = 32'h9e37_79b9;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  localparam logic [1:0] REG_KEY_0 = 2'd0;
  localparam logic [1:0] REG_KEY_1 = 2'd1;
  localparam logic [1:0] REG_KEY_2 = 2'd2;
  localparam logic [1:0] REG_KEY_3 = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  in_item_t    in_i;
  logic        out_valid_o;
  out_item_t   out_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  logic [31:0] key_words [4];
  logic [31:0] blk_words [STORE_DEPTH];
  int unsigned blk_fill = 0;
  logic        blk_mode = 1'b0;
  logic        blk_overflow = 1'b0;
  out_item_t   pending_words [$];
  int unsigned idle_pct = 0;
  int unsigned errors_seen = 0;
  int unsigned cycle_count = 0;

  xxtea_block_cipher_core #(
    .MAX_WORDS(STORE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] tea_mix(input logic [31:0] sum, input logic [31:0] y,
                                          input logic [31:0] z, input int unsigned p,
                                          input logic [1:0] e);
    logic [31:0] lhs;
    logic [31:0] rhs;
    lhs = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    rhs = (sum ^ y) + (key_words[2'(p) ^ e] ^ z);
    return lhs ^ rhs;
  endfunction

  task automatic cipher_predict(input in_item_t it);
    int unsigned n;
    int unsigned rounds;
    int unsigned p;
    logic [31:0] sum;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  e;
    status_e     st;
    out_item_t   res;
    if (blk_fill == 0) blk_mode = it.mode;
    if (blk_fill < STORE_DEPTH) begin
      blk_words[blk_fill] = it.data_word;
      blk_fill++;
    end else begin
      blk_overflow = 1'b1;
    end
    if (!it.last_word) return;
    n = blk_fill;
    rounds = 6 + 52 / n;
    if (blk_overflow) begin
      st = ST_LONG;
    end else if (n < 2) begin
      st = ST_SHORT;
    end else if (!blk_mode) begin
      st = ST_OK;
      sum = '0;
      z = blk_words[n-1];
      repeat (rounds) begin
        sum = sum + TEA_DELTA;
        e = sum[3:2];
        for (p = 0; p < n - 1; p++) begin
          y = blk_words[p+1];
          blk_words[p] = blk_words[p] + tea_mix(sum, y, z, p, e);
          z = blk_words[p];
        end
        y = blk_words[0];
        blk_words[n-1] = blk_words[n-1] + tea_mix(sum, y, z, n - 1, e);
        z = blk_words[n-1];
      end
    end else begin
      st = ST_OK;
      sum = rounds * TEA_DELTA;
      y = blk_words[0];
      repeat (rounds) begin
        e = sum[3:2];
        for (p = n - 1; p > 0; p--) begin
          z = blk_words[p-1];
          blk_words[p] = blk_words[p] - tea_mix(sum, y, z, p, e);
          y = blk_words[p];
        end
        z = blk_words[n-1];
        blk_words[0] = blk_words[0] - tea_mix(sum, y, z, 0, e);
        y = blk_words[0];
        sum = sum - TEA_DELTA;
      end
    end
    for (p = 0; p < n; p++) begin
      res.out_word = blk_words[p];
      res.out_last = (p + 1 == n);
      res.status   = st;
      pending_words.push_back(res);
    end
    blk_fill = 0;
    blk_mode = 1'b0;
    blk_overflow = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_valid_o) begin
      got = out_o;
      if (pending_words.size() == 0) begin
        $error("unexpected result: out_word %h out_last %0b status %0d",
               got.out_word, got.out_last, got.status);
        errors_seen++;
      end else begin
        want = pending_words.pop_front();
        if (got.out_word !== want.out_word) begin
          $error("out_word mismatch: expected %h, got %h", want.out_word, got.out_word);
          errors_seen++;
        end
        if (got.out_last !== want.out_last) begin
          $error("out_last mismatch: expected %0b, got %0b", want.out_last, got.out_last);
          errors_seen++;
        end
        if (got.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, got.status);
          errors_seen++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    key_words[idx] = value;
  endtask

  task automatic program_key(input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3);
    write_reg(REG_KEY_0, k0);
    write_reg(REG_KEY_1, k1);
    write_reg(REG_KEY_2, k2);
    write_reg(REG_KEY_3, k3);
    cfg_we_i <= 1'b0;
  endtask

  // hold start until the transfer, then predict
  task automatic send_word(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= it;
    do @(posedge clk_i); while (busy_o);
    cipher_predict(it);
  endtask

  task automatic send_block(input logic first_mode, input logic [31:0] words[$]);
    in_item_t it;
    for (int i = 0; i < words.size(); i++) begin
      it.mode      = (i == 0) ? first_mode : 1'($urandom);
      it.data_word = words[i];
      it.last_word = (i == words.size() - 1);
      send_word(it);
    end
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_key();
    send_block(1'b0, '{32'h0000_0000, 32'hffff_ffff});
    send_block(1'b1, '{32'hffff_ffff, 32'h0000_0000});
    wait_for_results();
  endtask

  task automatic test_short_block();
    send_block(1'b0, '{32'hffff_ffff});
    send_block(1'b1, '{32'h0000_0000});
  endtask

  task automatic test_small_blocks();
    send_block(1'b0, '{32'h8000_0000, 32'h0000_0001, 32'haaaa_aaaa});
    send_block(1'b1, '{32'h5555_5555, 32'hffff_ffff, 32'h7fff_fffe});
    send_block(1'b0, '{32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000,
                       32'hdead_beef});
    send_block(1'b1, '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210});
    wait_for_results();
  endtask

  task automatic test_store_limits();
    logic [31:0] words[$];
    repeat (STORE_DEPTH) words.push_back($urandom);
    send_block(1'b0, words);
    wait_for_results();
    words.delete();
    repeat (STORE_DEPTH + 2) words.push_back($urandom);
    send_block(1'b1, words);
    wait_for_results();
  endtask

  task automatic test_random_blocks(input int unsigned budget);
    logic [31:0] words[$];
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 10)      n = 1;
      else if (pick < 75) n = $urandom_range(6, 2);
      else if (pick < 96) n = $urandom_range(20, 7);
      else                n = $urandom_range(STORE_DEPTH + 3, 21);
      words.delete();
      repeat (n) words.push_back($urandom);
      send_block(1'($urandom), words);
      sent += n;
    end
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    in_i       <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_KEY_0;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    program_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    test_short_block();
    test_small_blocks();
    test_store_limits();

    program_key($urandom, $urandom, $urandom, $urandom);
    idle_pct = 7;
    test_random_blocks(20);

    program_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    idle_pct = 73;
    test_random_blocks(20);

    program_key(32'h0000_0000, 32'hffff_ffff, $urandom, $urandom);
    idle_pct = 0;
    test_random_blocks(20);

    if (errors_seen == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### xxtea_block_cipher_core.f
rtl/xxtea_pkg.sv
rtl/xxtea_ctrl.sv
rtl/xxtea_dp.sv
rtl/xxtea_block_cipher_core.sv
bench/testbench.sv
